FILE: rtl/pkut_pkg.sv
// Shared types and constants for the per-user key table.
package pkut_pkg;

  localparam int ENTRIES = 16;
  localparam int KEY_W   = 32;
  localparam int UID_W   = 32;

  typedef enum logic {
    OP_SET = 1'b0,
    OP_GET = 1'b1
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [UID_W-1:0] user_id;
    logic [KEY_W-1:0] key_low;
    logic [KEY_W-1:0] key_high;
  } req_t;

  // Per-cycle strobes broadcast from the sequencer to every cell.
  typedef struct packed {
    logic cmp;
    logic scan;
    logic write;
    logic any_hit;
  } ctrl_t;

  // Data passed from one cell to the next, lowest slot first.
  typedef struct packed {
    logic             hit_seen;
    logic             free_seen;
    logic [KEY_W-1:0] key_low;
    logic [KEY_W-1:0] key_high;
  } link_t;

endpackage

FILE: rtl/pkut_cell.sv
// One table slot: owner, key words and valid mark, with its link in the priority chain.
module pkut_cell
  import pkut_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  req_t  req,
  input  ctrl_t ctrl,
  input  link_t link_in,
  output link_t link_out
);

  logic [UID_W-1:0] owner;
  logic [KEY_W-1:0] key_low;
  logic [KEY_W-1:0] key_high;
  logic             valid;
  logic             hit;
  logic             free;
  logic             sel_hit;
  logic             sel_free;
  logic             first_hit;
  logic             first_free;
  logic             nonzero;

  assign first_hit  = hit && !link_in.hit_seen;
  assign first_free = free && !link_in.free_seen;
  assign nonzero    = (req.key_low != '0) || (req.key_high != '0);

  always_comb begin
    link_out.hit_seen  = link_in.hit_seen | hit;
    link_out.free_seen = link_in.free_seen | free;
    link_out.key_low   = link_in.key_low | (first_hit ? key_low : '0);
    link_out.key_high  = link_in.key_high | (first_hit ? key_high : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      hit      <= 1'b0;
      free     <= 1'b0;
      sel_hit  <= 1'b0;
      sel_free <= 1'b0;
    end else begin
      if (ctrl.cmp) begin
        hit  <= valid && (owner == req.user_id);
        free <= !valid;
      end
      if (ctrl.scan) begin
        sel_hit  <= first_hit;
        sel_free <= first_free;
      end
      if (ctrl.write && req.op == OP_SET) begin
        if (sel_hit) begin
          if (!nonzero) begin
            valid <= 1'b0;
          end
        end else if (!ctrl.any_hit && nonzero && sel_free) begin
          valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.write && req.op == OP_SET) begin
      if (sel_hit && nonzero) begin
        key_low  <= req.key_low;
        key_high <= req.key_high;
      end else if (!sel_hit && !ctrl.any_hit && nonzero && sel_free) begin
        owner    <= req.user_id;
        key_low  <= req.key_low;
        key_high <= req.key_high;
      end
    end
  end

endmodule

FILE: rtl/per_user_key_table_unit.sv
// Top level of the per-user key table: request sequencer, cell chain and result register.
//
// A row of ENTRIES cells, one per slot, each holding an owner id, two key
// words and a valid mark. A request is latched at acceptance and its result
// appears on the master side after these steps in order: compare in every
// cell, a scan along the cell chain that picks the lowest matching and lowest
// free slot and gathers the matching keys, then the write-back into the
// chosen cell together with loading the result register. The scan is a
// ripple through the chain, so its length sets the clock; the four-state
// sequencer takes no new request until it is back in idle. A new request is
// taken while an earlier result still waits on the master side; the
// write-back stalls only if that result has not been taken by then. Reset
// clears all valid marks.
module per_user_key_table_unit
  import pkut_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // user_id[31:0], key_low[63:32], key_high[95:64]
  input  logic [0:0]  s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata    // status[0], found[1], found_low[33:2],
                                 // found_high[65:34], zero fill
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CMP   = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_WRITE = 4'b1000
  } state_t;

  state_t           state;
  state_t           state_next;
  req_t             req;
  ctrl_t            ctrl;
  link_t            chain [ENTRIES+1];
  logic             any_hit;
  logic             any_free;
  logic [KEY_W-1:0] hit_low;
  logic [KEY_W-1:0] hit_high;
  logic             out_free;
  logic             advance;
  logic             nonzero;
  logic             res_status;
  logic             res_found;
  logic [KEY_W-1:0] res_low;
  logic [KEY_W-1:0] res_high;

  assign out_free = !m_tvalid || m_tready;
  assign advance  = (state == ST_WRITE) && out_free;
  assign s_tready = (state == ST_IDLE);
  assign nonzero  = (req.key_low != '0) || (req.key_high != '0);

  always_comb begin
    ctrl.cmp     = (state == ST_CMP);
    ctrl.scan    = (state == ST_SCAN);
    ctrl.write   = advance;
    ctrl.any_hit = any_hit;
  end

  assign chain[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    pkut_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .req      (req),
      .ctrl     (ctrl),
      .link_in  (chain[i]),
      .link_out (chain[i+1])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_CMP;
      ST_CMP:   state_next = ST_SCAN;
      ST_SCAN:  state_next = ST_WRITE;
      ST_WRITE: if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req.op       <= op_t'(s_tuser[0]);
      req.user_id  <= s_tdata[31:0];
      req.key_low  <= s_tdata[63:32];
      req.key_high <= s_tdata[95:64];
    end
    if (state == ST_SCAN) begin
      any_hit  <= chain[ENTRIES].hit_seen;
      any_free <= chain[ENTRIES].free_seen;
      hit_low  <= chain[ENTRIES].key_low;
      hit_high <= chain[ENTRIES].key_high;
    end
    if (advance) begin
      if (req.op == OP_GET) begin
        res_status <= 1'b0;
        res_found  <= any_hit;
        res_low    <= hit_low;
        res_high   <= hit_high;
      end else begin
        res_status <= !any_hit && nonzero && !any_free;
        res_found  <= 1'b0;
        res_low    <= '0;
        res_high   <= '0;
      end
    end
  end

  assign m_tdata = {6'd0, res_high, res_low, res_found, res_status};

endmodule
